FILE: rtl/egd_pkg.sv
package egd_pkg;

    localparam int FLOORS = 16;
    localparam int CARS = 4;
    localparam int FW = $clog2(FLOORS);
    localparam int CW = (CARS > 1) ? $clog2(CARS) : 1;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_CALL = 2'd1;
    localparam logic [1:0] OP_DEST = 2'd2;
    localparam logic [1:0] OP_RSVD = 2'd3;

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_UP = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [2:0] car_index;
        logic [3:0] floor_num;
        logic       call_dir;
    } egd_in_t;

    typedef struct packed {
        logic [2:0]  car_id;
        logic [3:0]  car_floor;
        logic [1:0]  car_dir;
        logic [3:0]  load_left;
        logic [3:0]  unload_left;
        logic [15:0] dest_mask;
        logic [15:0] up_calls;
        logic [15:0] down_calls;
        logic        status;
        logic        last;
    } egd_out_t;

endpackage

FILE: rtl/elevator_group_dispatcher_core.sv
// channel   | handshake              | payload
// s_ input  | s_valid / s_ready      | s_data  (egd_in_t)
// m_ result | m_valid / m_ready      | m_data  (egd_out_t)
// cfg       | cfg_valid / cfg_ready  | cfg_data (door_time, 4 bits)
// a tick takes each car in turn through timers and floor checks (ST_PREP), a
// floor scan (ST_SCAN) and an other-car compare (ST_CMP), both passed through
// when the car serves its own floor, then a decide/move step (ST_DEC) and a
// report step (ST_OUT) that waits on m_ready.
// calls and destinations are answered from idle with one result word on m_data.
// synchronous active-low reset clears all car and call state; door_time = 3.
// s_ready is low while an item is in work or a result waits on m_ready.
module elevator_group_dispatcher_core
    import egd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  egd_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output egd_out_t m_data,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic [3:0] cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_CMP = 3'd3;
    localparam logic [2:0] ST_DEC = 3'd4;
    localparam logic [2:0] ST_OUT = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [3:0] door_reg;
    logic [FW-1:0] flr_reg [CARS];
    logic [1:0] dir_reg [CARS];
    logic [3:0] ld_reg [CARS];
    logic [3:0] ul_reg [CARS];
    logic [FLOORS-1:0] dst_reg [CARS];
    logic [FLOORS-1:0] up_reg, dn_reg;
    logic [CW-1:0] car_reg;
    logic [FW-1:0] j_reg;
    logic [CW-1:0] k_reg;
    logic da_reg, db_reg, ra_reg, rb_reg, bu_reg, bd_reg, ou_reg, od_reg, done_reg;
    logic [FW-1:0] hi_reg, lo_reg;
    logic m_valid_reg;
    egd_out_t m_data_reg;

    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    // shared per-cycle compare terms
    logic [FW-1:0] cur;
    logic [FLOORS-1:0] cbit, calls;
    logic [4:0] of5, cur5, hi5, lo5;
    logic upish, downish, self_k;
    always_comb begin
        cur = flr_reg[car_reg];
        cbit = FLOORS'(1) << cur;
        calls = up_reg | dn_reg;
        of5 = 5'(flr_reg[k_reg]);
        cur5 = 5'(cur);
        hi5 = 5'(hi_reg);
        lo5 = 5'(lo_reg);
        upish = (dir_reg[k_reg] == DIR_UP) || (dir_reg[k_reg] == DIR_STOP);
        downish = (dir_reg[k_reg] == DIR_DOWN) || (dir_reg[k_reg] == DIR_STOP);
        self_k = (k_reg == car_reg);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid && s_ready && s_data.op == OP_TICK) state_next = ST_PREP;
            ST_PREP: state_next = ST_SCAN;
            ST_SCAN: if (done_reg || j_reg == FW'(FLOORS - 1)) state_next = ST_CMP;
            ST_CMP: if (done_reg || k_reg == CW'(CARS - 1)) state_next = ST_DEC;
            ST_DEC: state_next = ST_OUT;
            ST_OUT: if (!m_valid_reg || m_ready) begin
                state_next = (car_reg == CW'(CARS - 1)) ? ST_IDLE : ST_PREP;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            door_reg <= 4'd3;
            m_valid_reg <= 1'b0;
            up_reg <= '0;
            dn_reg <= '0;
            car_reg <= '0;
            for (int i = 0; i < CARS; i++) begin
                flr_reg[i] <= '0;
                dir_reg[i] <= DIR_STOP;
                ld_reg[i] <= '0;
                ul_reg[i] <= '0;
                dst_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_valid) door_reg <= cfg_data;
            if (m_valid_reg && m_ready && state_reg != ST_OUT) m_valid_reg <= 1'b0;
            case (state_reg)
                // calls and destinations answer at once
                ST_IDLE: if (s_valid && s_ready) begin
                    egd_out_t r;
                    logic [CW-1:0] ci;
                    logic [FLOORS-1:0] fbit;
                    r = '0;
                    r.last = 1'b1;
                    r.status = 1'b1;
                    r.up_calls = 16'(up_reg);
                    r.down_calls = 16'(dn_reg);
                    ci = s_data.car_index[CW-1:0];
                    fbit = FLOORS'(1) << s_data.floor_num[FW-1:0];
                    car_reg <= '0;
                    if (s_data.op == OP_CALL) begin
                        if (32'(s_data.floor_num) < FLOORS) begin
                            r.status = 1'b0;
                            if (!s_data.call_dir) begin
                                up_reg <= up_reg | fbit;
                                r.up_calls = 16'(up_reg | fbit);
                            end else begin
                                dn_reg <= dn_reg | fbit;
                                r.down_calls = 16'(dn_reg | fbit);
                            end
                        end
                    end else if (s_data.op == OP_DEST) begin
                        r.car_id = s_data.car_index;
                        if (32'(s_data.car_index) < CARS) begin
                            r.car_floor = 4'(flr_reg[ci]);
                            r.car_dir = dir_reg[ci];
                            r.load_left = ld_reg[ci];
                            r.unload_left = ul_reg[ci];
                            r.dest_mask = 16'(dst_reg[ci]);
                            if (32'(s_data.floor_num) < FLOORS
                                && s_data.floor_num[FW-1:0] != flr_reg[ci]) begin
                                r.status = 1'b0;
                                dst_reg[ci] <= dst_reg[ci] | fbit;
                                r.dest_mask = 16'(dst_reg[ci] | fbit);
                                if (dir_reg[ci] == DIR_STOP) begin
                                    r.car_dir = (s_data.floor_num[FW-1:0] < flr_reg[ci])
                                        ? DIR_DOWN : DIR_UP;
                                    dir_reg[ci] <= r.car_dir;
                                end
                            end
                        end
                    end
                    if (s_data.op != OP_TICK) m_valid_reg <= 1'b1;
                    m_data_reg <= r;
                end
                // timers, top floor stop and serving the current floor
                ST_PREP: begin
                    logic [3:0] ld, ul;
                    logic [1:0] d;
                    logic served;
                    ld = (ld_reg[car_reg] != 0) ? ld_reg[car_reg] - 4'd1 : 4'd0;
                    ul = (ul_reg[car_reg] != 0) ? ul_reg[car_reg] - 4'd1 : 4'd0;
                    d = dir_reg[car_reg];
                    if (cur == FW'(FLOORS - 1) && d == DIR_UP) d = DIR_STOP;
                    served = 1'b1;
                    if ((dst_reg[car_reg] & cbit) != 0) begin
                        dst_reg[car_reg] <= dst_reg[car_reg] & ~cbit;
                        if (ul == 0) ul = door_reg;
                    end else if ((up_reg & cbit) != 0 && d != DIR_DOWN) begin
                        d = DIR_UP;
                        up_reg <= up_reg & ~cbit;
                        if (ld == 0) ld = door_reg;
                    end else if ((dn_reg & cbit) != 0 && d != DIR_UP) begin
                        d = DIR_DOWN;
                        dn_reg <= dn_reg & ~cbit;
                        if (ld == 0) ld = door_reg;
                    end else begin
                        served = 1'b0;
                    end
                    done_reg <= served;
                    ld_reg[car_reg] <= ld;
                    ul_reg[car_reg] <= ul;
                    dir_reg[car_reg] <= d;
                    j_reg <= '0;
                    k_reg <= '0;
                    {da_reg, db_reg, ra_reg, rb_reg} <= '0;
                    {bu_reg, bd_reg, ou_reg, od_reg} <= '0;
                    hi_reg <= '0;
                    lo_reg <= '0;
                end
                // one floor per cycle; nearest above keeps first, below keeps last
                ST_SCAN: if (!done_reg) begin
                    if (j_reg > cur) begin
                        if (dst_reg[car_reg][j_reg]) da_reg <= 1'b1;
                        if (calls[j_reg] && !ra_reg) begin
                            ra_reg <= 1'b1;
                            hi_reg <= j_reg;
                        end
                    end else if (j_reg < cur) begin
                        if (dst_reg[car_reg][j_reg]) db_reg <= 1'b1;
                        if (calls[j_reg]) begin
                            rb_reg <= 1'b1;
                            lo_reg <= j_reg;
                        end
                    end
                    j_reg <= j_reg + FW'(1);
                end
                // one car per cycle; the car itself is skipped
                ST_CMP: if (!done_reg) begin
                    if (!self_k) begin
                        if (upish && ra_reg && ((of5 > cur5 && of5 <= hi5)
                            || (of5 == cur5 && k_reg < car_reg))) bu_reg <= 1'b1;
                        if (downish && rb_reg && ((of5 < cur5 && of5 >= lo5)
                            || (of5 == cur5 && k_reg < car_reg))) bd_reg <= 1'b1;
                        if (upish && rb_reg && lo5 >= of5
                            && (lo5 - of5) < (cur5 - lo5)) ou_reg <= 1'b1;
                        if (downish && ra_reg && of5 >= hi5
                            && (of5 - hi5) < (hi5 - cur5)) od_reg <= 1'b1;
                    end
                    k_reg <= k_reg + CW'(1);
                end
                // direction rule and move
                ST_DEC: begin
                    logic [1:0] d;
                    d = dir_reg[car_reg];
                    if (!done_reg) begin
                        if (!da_reg && !ra_reg && !db_reg && !rb_reg) d = DIR_STOP;
                        else if (da_reg && (d == DIR_STOP || d == DIR_UP)) d = DIR_UP;
                        else if (db_reg && (d == DIR_STOP || d == DIR_DOWN)) d = DIR_DOWN;
                        else if ((d == DIR_UP || d == DIR_STOP) && ra_reg && !bu_reg
                            && !od_reg) d = DIR_UP;
                        else if ((d == DIR_DOWN || d == DIR_STOP) && rb_reg && !bd_reg
                            && !ou_reg) d = DIR_DOWN;
                        else d = DIR_STOP;
                    end
                    dir_reg[car_reg] <= d;
                    if (ld_reg[car_reg] == 0 && ul_reg[car_reg] == 0) begin
                        if (d == DIR_UP && cur < FW'(FLOORS - 1))
                            flr_reg[car_reg] <= cur + FW'(1);
                        else if (d == DIR_DOWN && cur > 0)
                            flr_reg[car_reg] <= cur - FW'(1);
                    end
                end
                // report word for this car
                ST_OUT: if (!m_valid_reg || m_ready) begin
                    m_valid_reg <= 1'b1;
                    m_data_reg.car_id <= 3'(car_reg);
                    m_data_reg.car_floor <= 4'(cur);
                    m_data_reg.car_dir <= dir_reg[car_reg];
                    m_data_reg.load_left <= ld_reg[car_reg];
                    m_data_reg.unload_left <= ul_reg[car_reg];
                    m_data_reg.dest_mask <= 16'(dst_reg[car_reg]);
                    m_data_reg.up_calls <= 16'(up_reg);
                    m_data_reg.down_calls <= 16'(dn_reg);
                    m_data_reg.status <= 1'b0;
                    m_data_reg.last <= (car_reg == CW'(CARS - 1));
                    if (car_reg != CW'(CARS - 1)) car_reg <= car_reg + CW'(1);
                end
                default: ;
            endcase
        end
    end

endmodule
